/* sv/dit_pkg.sv */
// Shared package for the disjoint interval tracker.
// Holds the transaction types, command and status codes, table entry type and sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package dit_pkg;

    // Fixed field widths of the transactions.
    localparam int VALUE_BITS        = 16;
    localparam int COUNT_BITS        = 6;
    localparam int DEF_MAX_INTERVALS = 32;

    typedef enum logic [0:0] {
        CMD_ADD  = 1'b0,
        CMD_READ = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_COVERED = 2'd0,
        ST_MERGED  = 2'd1,
        ST_NEW     = 2'd2,
        ST_DROPPED = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd                  command;
        logic [VALUE_BITS-1:0] value;
    } t_in_item;

    typedef struct packed {
        t_status               status;
        logic [VALUE_BITS-1:0] interval_start;
        logic [VALUE_BITS-1:0] interval_end;
        logic                  interval_valid;
        logic                  last;
        logic [COUNT_BITS-1:0] interval_count;
    } t_out_item;

    // One stored interval: first and final value.
    typedef struct packed {
        logic [VALUE_BITS-1:0] lo;
        logic [VALUE_BITS-1:0] hi;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DECIDE,
        S_MOVE_RD,
        S_MOVE_WR,
        S_PLACE,
        S_RO_RD,
        S_RO_OUT,
        S_EMIT
    } t_state;

endpackage

/* sv/dit_table.sv */
// Interval table memory for the disjoint interval tracker.
// One write port and one read port with registered read data; uses dit_pkg.
`timescale 1ns / 1ps

module dit_table #(
    parameter int DEPTH = dit_pkg::DEF_MAX_INTERVALS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  dit_pkg::t_entry i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output dit_pkg::t_entry o_rdata
);
    import dit_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/dit_seq.sv */
// Sequencer of the disjoint interval tracker: scans the table with one comparator,
// decides the update, moves entries one at a time and streams out reads. Uses dit_pkg.
`timescale 1ns / 1ps

module dit_seq #(
    parameter int MAX_INTERVALS = dit_pkg::DEF_MAX_INTERVALS,
    parameter int AW            = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input transaction channel.
    input  logic               i_in_valid,
    input  dit_pkg::t_in_item  i_in_data,
    output logic               o_in_stall,
    // Result towards the output register.
    output logic               o_res_valid,
    output dit_pkg::t_out_item o_res_data,
    input  logic               i_res_ready,
    // Table memory port.
    output logic               o_we,
    output logic [AW-1:0]      o_waddr,
    output dit_pkg::t_entry    o_wdata,
    output logic               o_re,
    output logic [AW-1:0]      o_raddr,
    input  dit_pkg::t_entry    i_rdata
);
    import dit_pkg::*;

    localparam int CW = $clog2(MAX_INTERVALS + 1);

    t_state              r_state, n_state;
    logic [VALUE_BITS-1:0] r_val;
    logic [CW-1:0]       r_idx;
    logic [CW-1:0]       r_pos;
    logic [CW-1:0]       r_count;
    logic                r_has_prev;
    logic                r_has_next;
    t_entry              r_prev;
    t_entry              r_next;
    t_status             r_status;
    logic                r_merge;

    logic [CW-1:0]       w_idx_inc;
    logic [CW-1:0]       w_idx_dec;
    logic                w_at_end;
    logic                w_before;
    logic                w_covered;
    logic                w_left;
    logic                w_right;
    logic                w_full;

    // Index arithmetic shared by scan, moves and readout.
    assign w_idx_inc = r_idx + CW'(1);
    assign w_idx_dec = r_idx - CW'(1);
    assign w_at_end  = (w_idx_inc == r_count);

    // Shared comparator: does the entry just read start at or below the value.
    assign w_before = (i_rdata.lo <= r_val);

    // Neighbor tests; adjacency is computed one bit wider so the top value never wraps.
    assign w_covered = r_has_prev && (r_prev.hi >= r_val);
    assign w_left    = r_has_prev &&
                       (({1'b0, r_prev.hi} + (VALUE_BITS+1)'(1)) == {1'b0, r_val});
    assign w_right   = r_has_next &&
                       ({1'b0, r_next.lo} == ({1'b0, r_val} + (VALUE_BITS+1)'(1)));
    assign w_full    = (r_count >= CW'(MAX_INTERVALS));

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.command == CMD_ADD) begin
                        n_state = (r_count == '0) ? S_DECIDE : S_SCAN_RD;
                    end else begin
                        n_state = (r_count == '0) ? S_EMIT : S_RO_RD;
                    end
                end
            end
            S_SCAN_RD: n_state = S_SCAN_CMP;
            S_SCAN_CMP: begin
                if (w_before && !w_at_end) begin
                    n_state = S_SCAN_RD;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (w_covered) begin
                    n_state = S_EMIT;
                end else if (w_left && w_right) begin
                    n_state = (w_idx_inc < r_count) ? S_MOVE_RD : S_EMIT;
                end else if (w_left || w_right || w_full) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = (r_idx < r_count) ? S_MOVE_RD : S_PLACE;
                end
            end
            S_MOVE_RD: n_state = S_MOVE_WR;
            S_MOVE_WR: begin
                if (r_merge) begin
                    n_state = (w_idx_inc < r_count) ? S_MOVE_RD : S_EMIT;
                end else begin
                    n_state = (w_idx_dec > r_pos) ? S_MOVE_RD : S_PLACE;
                end
            end
            S_PLACE: n_state = S_EMIT;
            S_RO_RD: n_state = S_RO_OUT;
            S_RO_OUT: begin
                if (i_res_ready) begin
                    n_state = w_at_end ? S_IDLE : S_RO_RD;
                end
            end
            S_EMIT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output logic: memory control, result and input stall.
    always_comb begin
        o_in_stall  = (r_state != S_IDLE);
        o_we        = 1'b0;
        o_waddr     = r_idx[AW-1:0];
        o_wdata     = i_rdata;
        o_re        = 1'b0;
        o_raddr     = r_idx[AW-1:0];
        o_res_valid = 1'b0;
        o_res_data  = '{status: r_status, interval_start: '0, interval_end: '0,
                        interval_valid: 1'b0, last: 1'b1,
                        interval_count: COUNT_BITS'(r_count)};
        unique case (r_state)
            S_SCAN_RD, S_RO_RD: begin
                o_re = 1'b1;
            end
            S_DECIDE: begin
                if (!w_covered && (w_left || w_right)) begin
                    o_we = 1'b1;
                    if (w_left && w_right) begin
                        o_waddr = w_idx_dec[AW-1:0];
                        o_wdata = '{lo: r_prev.lo, hi: r_next.hi};
                    end else if (w_left) begin
                        o_waddr = w_idx_dec[AW-1:0];
                        o_wdata = '{lo: r_prev.lo, hi: r_val};
                    end else begin
                        o_wdata = '{lo: r_val, hi: r_next.hi};
                    end
                end
            end
            S_MOVE_RD: begin
                o_re    = 1'b1;
                o_raddr = r_merge ? w_idx_inc[AW-1:0] : w_idx_dec[AW-1:0];
            end
            S_MOVE_WR: begin
                o_we = 1'b1;
            end
            S_PLACE: begin
                o_we    = 1'b1;
                o_waddr = r_pos[AW-1:0];
                o_wdata = '{lo: r_val, hi: r_val};
            end
            S_RO_OUT: begin
                o_res_valid = 1'b1;
                o_res_data  = '{status: ST_COVERED, interval_start: i_rdata.lo,
                                interval_end: i_rdata.hi, interval_valid: 1'b1,
                                last: w_at_end, interval_count: COUNT_BITS'(r_count)};
            end
            S_EMIT: begin
                o_res_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // State and count registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DECIDE && !w_covered) begin
                if (w_left && w_right) begin
                    r_count <= r_count - CW'(1);
                end else if (!w_left && !w_right && !w_full) begin
                    r_count <= r_count + CW'(1);
                end
            end
        end
    end

    // Working registers of the current transaction.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_val      <= i_in_data.value;
                    r_idx      <= '0;
                    r_has_prev <= 1'b0;
                    r_has_next <= 1'b0;
                    r_status   <= ST_COVERED;
                end
            end
            S_SCAN_CMP: begin
                if (w_before) begin
                    r_prev     <= i_rdata;
                    r_has_prev <= 1'b1;
                    r_idx      <= w_idx_inc;
                end else begin
                    r_next     <= i_rdata;
                    r_has_next <= 1'b1;
                end
            end
            S_DECIDE: begin
                r_pos <= r_idx;
                if (w_covered) begin
                    r_status <= ST_COVERED;
                end else if (w_left && w_right) begin
                    r_status <= ST_MERGED;
                    r_merge  <= 1'b1;
                end else if (w_left || w_right) begin
                    r_status <= ST_MERGED;
                end else if (w_full) begin
                    r_status <= ST_DROPPED;
                end else begin
                    r_status <= ST_NEW;
                    r_merge  <= 1'b0;
                    r_idx    <= r_count;
                end
            end
            S_MOVE_WR: begin
                r_idx <= r_merge ? w_idx_inc : w_idx_dec;
            end
            S_RO_OUT: begin
                if (i_res_ready && !w_at_end) begin
                    r_idx <= w_idx_inc;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

/* sv/disjoint_interval_tracker.sv */
// Top level of the disjoint interval tracker: sequencer, table memory and output register.
// Uses dit_pkg, dit_seq and dit_table.
`timescale 1ns / 1ps

// The tracker keeps a sorted table of up to MAX_INTERVALS disjoint, non-adjacent intervals.
// An add transaction is taken only while the block is idle and scans the table through a
// single read port, each entry read and then compared, up to the insertion point; a merge of
// two entries or a new entry then moves every later entry by one place, again with a read and
// a write per entry, and the single result follows. The block takes the next transaction only
// once that result has entered the output register. A read transaction streams one result
// per stored interval, each made by a table read and then presentation, with last set on the
// final one; an empty table gives a single result with interval_valid low. Output stalls
// hold the block up once the output register is occupied. The table needs no clearing after
// reset: entries beyond the stored count are never read. A finished result sits in an output
// register, so a stalled output holds up the last internal step only while that register
// is occupied.
module disjoint_interval_tracker #(
    parameter int MAX_INTERVALS = dit_pkg::DEF_MAX_INTERVALS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  dit_pkg::t_in_item  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output dit_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);
    import dit_pkg::*;

    localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;

    logic            w_res_valid;
    t_out_item       w_res_data;
    logic            w_res_ready;
    logic            w_we;
    logic [AW-1:0]   w_waddr;
    t_entry          w_wdata;
    logic            w_re;
    logic [AW-1:0]   w_raddr;
    t_entry          w_rdata;
    logic            r_out_valid;
    t_out_item       r_out_data;

    dit_seq #(
        .MAX_INTERVALS(MAX_INTERVALS),
        .AW           (AW)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_res_valid(w_res_valid),
        .o_res_data (w_res_data),
        .i_res_ready(w_res_ready),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .o_re       (w_re),
        .o_raddr    (w_raddr),
        .i_rdata    (w_rdata)
    );

    dit_table #(
        .DEPTH(MAX_INTERVALS),
        .AW   (AW)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // The output register takes a new result when empty or when its content leaves.
    assign w_res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out_data <= w_res_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // A result without an interval is always the final one of its transaction.
    a_plain_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.interval_valid) |-> o_out_data.last)
        else $error("result without interval not marked last");

    // Intervals read out of the table are never reversed.
    a_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.interval_valid) |->
        (o_out_data.interval_start <= o_out_data.interval_end))
        else $error("interval read out with start above end");

    // An accepted transaction keeps the block busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a transaction was taken");

    // A dropped value is reported only with a full table.
    a_drop_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_DROPPED) |->
        (o_out_data.interval_count == COUNT_BITS'(MAX_INTERVALS)))
        else $error("value dropped while table not full");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the disjoint interval tracker.
// Predicts every result from a shadow copy of the interval table; depends on dit_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;

    import dit_pkg::*;

    localparam int MAX_ENTRIES = DEF_MAX_INTERVALS;
    localparam int TOTAL_ITEMS = 260;
    localparam int WINDOW      = 120;
    localparam int TOP_VALUE   = (1 << VALUE_BITS) - 1;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    t_in_item  in_data;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;
    logic      out_stall;

    // Shadow copy of the interval table, updated when each transaction is accepted.
    int shadow_lo [MAX_ENTRIES];
    int shadow_hi [MAX_ENTRIES];
    int shadow_count = 0;

    // Results still owed by the block, oldest first.
    t_out_item due_results [$];

    int  n_sent         = 0;
    int  mismatch_count = 0;
    int  hold_left      = 0;
    int  stall_left     = 0;
    bit  quiet          = 1'b0;

    disjoint_interval_tracker u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Run limit, far beyond the slowest passing run.
    initial begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

    // Mostly short idle gaps, a few long ones, none at all during quiet stretches.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet) begin
            return 0;
        end
        if (r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(11, 40);
    endfunction

    // Append one expected result to the tail of the owed list.
    task automatic owe_result(input t_out_item item);
        due_results = {due_results, item};
    endtask

    // Apply one accepted transaction to the shadow table and queue the results it causes.
    task automatic shadow_apply(input t_in_item item);
        int        v;
        int        pos;
        int        j;
        bit        left_adj;
        bit        right_adj;
        t_status   st;
        t_out_item r;
        v = int'(item.value);
        r = '0;
        if (item.command == CMD_ADD) begin
            pos = 0;
            while (pos < shadow_count && shadow_lo[pos] <= v) begin
                pos++;
            end
            left_adj  = (pos > 0) && (shadow_hi[pos-1] + 1 == v);
            right_adj = (pos < shadow_count) && (shadow_lo[pos] == v + 1);
            if (pos > 0 && shadow_hi[pos-1] >= v) begin
                st = ST_COVERED;
            end else if (left_adj && right_adj) begin
                // The value closes the one-value gap: the two neighbors become one entry.
                shadow_hi[pos-1] = shadow_hi[pos];
                for (j = pos; j + 1 < shadow_count; j++) begin
                    shadow_lo[j] = shadow_lo[j+1];
                    shadow_hi[j] = shadow_hi[j+1];
                end
                shadow_count--;
                st = ST_MERGED;
            end else if (left_adj) begin
                shadow_hi[pos-1] = v;
                st = ST_MERGED;
            end else if (right_adj) begin
                shadow_lo[pos] = v;
                st = ST_MERGED;
            end else if (shadow_count >= MAX_ENTRIES) begin
                st = ST_DROPPED;
            end else begin
                for (j = shadow_count; j > pos; j--) begin
                    shadow_lo[j] = shadow_lo[j-1];
                    shadow_hi[j] = shadow_hi[j-1];
                end
                shadow_lo[pos] = v;
                shadow_hi[pos] = v;
                shadow_count++;
                st = ST_NEW;
            end
            r.status         = st;
            r.last           = 1'b1;
            r.interval_count = COUNT_BITS'(shadow_count);
            owe_result(r);
        end else if (shadow_count == 0) begin
            // An empty table still answers with one result, marked not valid.
            r.last = 1'b1;
            owe_result(r);
        end else begin
            for (j = 0; j < shadow_count; j++) begin
                r.status         = ST_COVERED;
                r.interval_start = VALUE_BITS'(shadow_lo[j]);
                r.interval_end   = VALUE_BITS'(shadow_hi[j]);
                r.interval_valid = 1'b1;
                r.last           = (j + 1 == shadow_count);
                r.interval_count = COUNT_BITS'(shadow_count);
                owe_result(r);
            end
        end
    endtask

    // Offer one transaction after a random gap and hold it until the block takes it.
    task automatic send_item(input t_cmd cmd, input int value);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
        in_valid        = 1'b1;
        in_data.command = cmd;
        in_data.value   = VALUE_BITS'(value);
        do begin
            @(posedge clk);
        end while (in_stall);
        shadow_apply(in_data);
        n_sent++;
    endtask

    // Add every value of the gap after entry idx, ascending, at most max_n of them.
    task automatic fill_gap(input int idx, input int max_n);
        int first;
        int stop;
        int v;
        first = shadow_hi[idx] + 1;
        stop  = shadow_lo[idx+1] - 1;
        for (v = first; v <= stop && v < first + max_n; v++) begin
            send_item(CMD_ADD, v);
        end
    endtask

    // Receiver side: random stalls, plus a long counted hold-off when requested.
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_stall = 1'b1;
                hold_left--;
            end else if (stall_left > 0) begin
                out_stall = 1'b1;
                stall_left--;
            end else begin
                out_stall = 1'b0;
                if ($urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // Compare every accepted result with the oldest one still owed.
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (due_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result %h at %0t", out_data, $realtime);
                end
            end else begin
                want = due_results.pop_front();
                if (out_data.status !== want.status ||
                    out_data.interval_start !== want.interval_start ||
                    out_data.interval_end !== want.interval_end ||
                    out_data.interval_valid !== want.interval_valid ||
                    out_data.last !== want.last ||
                    out_data.interval_count !== want.interval_count) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch at %0t: expected st=%0d [%0d..%0d] v=%b last=%b cnt=%0d",
                                 $realtime, want.status, want.interval_start,
                                 want.interval_end, want.interval_valid, want.last,
                                 want.interval_count);
                        $display("              actual   st=%0d [%0d..%0d] v=%b last=%b cnt=%0d",
                                 out_data.status, out_data.interval_start,
                                 out_data.interval_end, out_data.interval_valid,
                                 out_data.last, out_data.interval_count);
                    end
                end
            end
        end
    end

    // Empty read, range extremes, cover, both kinds of extension and bridging.
    task automatic test_directed();
        send_item(CMD_READ, 16'hFFFF);
        send_item(CMD_ADD, 0);
        send_item(CMD_ADD, 0);
        // The top value must not count as adjacent to zero.
        send_item(CMD_ADD, TOP_VALUE);
        send_item(CMD_ADD, TOP_VALUE - 1);
        send_item(CMD_ADD, 1);
        send_item(CMD_ADD, 3);
        send_item(CMD_ADD, 2);
        send_item(CMD_ADD, 100);
        send_item(CMD_ADD, 98);
        send_item(CMD_ADD, 99);
        send_item(CMD_ADD, 16'hAAAA);
        send_item(CMD_ADD, 16'h5555);
        send_item(CMD_ADD, 16'h5556);
        send_item(CMD_READ, 0);
        send_item(CMD_ADD, 3);
        send_item(CMD_ADD, TOP_VALUE);
        send_item(CMD_ADD, 101);
        send_item(CMD_READ, 16'h5A5A);
    endtask

    // Fill the table, then check dropped values, extension while full and a full readout.
    task automatic test_table_full();
        int tries;
        int idx;
        tries = 0;
        while (shadow_count < MAX_ENTRIES && tries < 300) begin
            // Multiples of three apart are never adjacent, so distinct ones open entries.
            send_item(CMD_ADD, 30000 + 3 * $urandom_range(0, 400));
            tries++;
        end
        send_item(CMD_ADD, 29000);
        send_item(CMD_ADD, 65000);
        send_item(CMD_ADD, 4);
        send_item(CMD_READ, 0);
        idx = 0;
        while (idx + 1 < shadow_count && shadow_lo[idx+1] - shadow_hi[idx] != 3) begin
            idx++;
        end
        if (idx + 1 < shadow_count) begin
            fill_gap(idx, 2);
        end
        send_item(CMD_ADD, 29000);
        send_item(CMD_READ, 0);
    endtask

    // The receiver holds off for a long time while items keep coming back to back.
    task automatic test_output_holdoff();
        int k;
        quiet     = 1'b1;
        hold_left = 250;
        for (k = 0; k < 6; k++) begin
            send_item(CMD_ADD, $urandom_range(0, TOP_VALUE));
        end
        send_item(CMD_READ, 0);
        for (k = 0; k < 5; k++) begin
            send_item(CMD_ADD, $urandom_range(0, TOP_VALUE));
        end
        quiet = 1'b0;
    endtask

    // Random mix: clustered adds, gap filling, extensions, covered values, reads and noise.
    task automatic test_random_mix();
        int r;
        int base;
        int idx;
        base = $urandom_range(0, TOP_VALUE - WINDOW);
        while (n_sent < TOTAL_ITEMS) begin
            quiet = (n_sent % 50) < 10;
            r = $urandom_range(0, 99);
            if (r < 35) begin
                send_item(CMD_ADD, base + $urandom_range(0, WINDOW));
            end else if (r < 50 && shadow_count >= 2) begin
                fill_gap($urandom_range(0, shadow_count - 2), 6);
            end else if (r < 62 && shadow_count > 0) begin
                idx = $urandom_range(0, shadow_count - 1);
                if ($urandom_range(0, 1) == 1 && shadow_lo[idx] > 0) begin
                    send_item(CMD_ADD, shadow_lo[idx] - 1);
                end else if (shadow_hi[idx] < TOP_VALUE) begin
                    send_item(CMD_ADD, shadow_hi[idx] + 1);
                end else begin
                    send_item(CMD_ADD, shadow_lo[idx]);
                end
            end else if (r < 72) begin
                send_item(CMD_READ, $urandom_range(0, TOP_VALUE));
            end else if (r < 80) begin
                send_item(CMD_ADD, $urandom_range(0, TOP_VALUE));
            end else if (r < 86) begin
                base = $urandom_range(0, TOP_VALUE - WINDOW);
            end else if (shadow_count > 0) begin
                idx = $urandom_range(0, shadow_count - 1);
                send_item(CMD_ADD, $urandom_range(shadow_lo[idx], shadow_hi[idx]));
            end else begin
                send_item(CMD_READ, 0);
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_table_full();
        test_output_holdoff();
        test_random_mix();

        @(negedge clk);
        in_valid = 1'b0;
        while (due_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);

        if (mismatch_count == 0 && due_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
